// File: src/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// shared constants, register codes and structs of the stream find-and-replace
// ----------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

   // default sizing of the top level
   localparam int MAX_FIND_DEF   = 8;
   localparam int MAX_PLACE_DEF  = 8;
   localparam int COUNT_BITS_DEF = 16;

   // fixed field widths
   localparam int BYTE_BITS    = 8;
   localparam int LEN_BITS     = 4;
   localparam int PAT_BITS     = 64;
   localparam int LIMIT_BITS   = 16;
   localparam int CSR_IDX_BITS = 3;

   // job slots cover the largest window and the largest replacement
   localparam int JOB_SLOTS = 8;

   // job queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // register indexes of the csr port
   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_FIND_PATTERN  = 3'd0,
      REG_FIND_LEN      = 3'd1,
      REG_PLACE_PATTERN = 3'd2,
      REG_PLACE_LEN     = 3'd3,
      REG_OUT_LIMIT     = 3'd4
   } csr_reg_type;

   // configuration as seen by front and back
   typedef struct packed {
      logic [PAT_BITS-1:0]   find_pattern;
      logic [LEN_BITS-1:0]   find_len;
      logic [PAT_BITS-1:0]   place_pattern;
      logic [LEN_BITS-1:0]   place_len;
      logic [LIMIT_BITS-1:0] out_limit;
   } cfg_type;

   // one job: the bytes a single input word releases, in order
   typedef struct packed {
      logic [JOB_SLOTS-1:0][BYTE_BITS-1:0] bytes;
      logic [LEN_BITS-1:0]                 count;
      logic                                last;
   } job_type;

   // head of the job queue
   typedef struct packed {
      logic    valid;
      job_type job;
   } queue_head_type;

endpackage

`default_nettype wire

// File: src/sfr_if.sv
// ----------------------------------------------------------------------------
// sfr channels
// valid/ready interfaces for text input, edited output and csr writes
// ----------------------------------------------------------------------------
`default_nettype none

interface sfr_req_if;
   logic                          valid;
   logic                          ready;
   logic [sfr_pkg::BYTE_BITS-1:0] in_byte;
   logic                          in_last;
   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface sfr_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [sfr_pkg::BYTE_BITS-1:0]  out_byte;
   logic                           byte_valid;
   logic                           out_last;
   logic [sfr_pkg::LIMIT_BITS-1:0] out_length;
   modport source (output valid, output out_byte, output byte_valid, output out_last,
                   output out_length, input ready);
   modport sink (input valid, input out_byte, input byte_valid, input out_last,
                 input out_length, output ready);
endinterface

interface sfr_csr_if;
   logic                             valid;
   logic                             ready;
   logic [sfr_pkg::CSR_IDX_BITS-1:0] index;
   logic [sfr_pkg::PAT_BITS-1:0]     data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: src/stream_find_and_replace.sv
// ----------------------------------------------------------------------------
// stream_find_and_replace
// streaming leftmost non-overlapping find-and-replace over a byte text
// ----------------------------------------------------------------------------
//
//  channel  dir  fields                                       handshake
//  req_ch   in   in_byte, in_last                             valid/ready
//  rsp_ch   out  out_byte, byte_valid, out_last, out_length   valid/ready
//  csr_ch   in   index, data                                  valid/ready (always ready)
//
//  one text word per cycle enters while the job queue has room; result words
//  leave the back one per cycle while the receiver is ready, one per byte
//  a four-job queue between front and back soaks up expansion bursts
//  a word that releases nothing and is not the final one costs no back cycle
//  a job whose bytes are all dropped by the limit is popped without a byte
//  synchronous reset clears control state; no clearing pass
`default_nettype none

module stream_find_and_replace #(
   parameter int MAX_FIND   = sfr_pkg::MAX_FIND_DEF,
   parameter int MAX_PLACE  = sfr_pkg::MAX_PLACE_DEF,
   parameter int COUNT_BITS = sfr_pkg::COUNT_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   sfr_req_if.sink   req_ch,
   sfr_rsp_if.source rsp_ch,
   sfr_csr_if.sink   csr_ch
);

   sfr_pkg::cfg_type        cfg_ff;
   sfr_pkg::job_type        job;
   sfr_pkg::queue_head_type head;
   logic                    job_push;
   logic                    job_pop;
   logic                    queue_full;
   logic                    csr_write;
   logic                    win_clear;

   assign csr_ch.ready = 1'b1;
   assign csr_write    = csr_ch.valid && csr_ch.ready;
   assign win_clear    = csr_write &&
                         (sfr_pkg::csr_reg_type'(csr_ch.index) == sfr_pkg::REG_FIND_LEN);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.find_pattern  <= '0;
         cfg_ff.find_len      <= sfr_pkg::LEN_BITS'(1);
         cfg_ff.place_pattern <= '0;
         cfg_ff.place_len     <= '0;
         cfg_ff.out_limit     <= '1;
      end else if (csr_write) begin
         unique case (sfr_pkg::csr_reg_type'(csr_ch.index))
            sfr_pkg::REG_FIND_PATTERN: begin
               cfg_ff.find_pattern <= csr_ch.data;
            end
            sfr_pkg::REG_FIND_LEN: begin
               cfg_ff.find_len <= csr_ch.data[sfr_pkg::LEN_BITS-1:0];
            end
            sfr_pkg::REG_PLACE_PATTERN: begin
               cfg_ff.place_pattern <= csr_ch.data;
            end
            sfr_pkg::REG_PLACE_LEN: begin
               cfg_ff.place_len <= csr_ch.data[sfr_pkg::LEN_BITS-1:0];
            end
            sfr_pkg::REG_OUT_LIMIT: begin
               cfg_ff.out_limit <= csr_ch.data[sfr_pkg::LIMIT_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // window and classification
   sfr_front #(
      .MAX_FIND  (MAX_FIND),
      .MAX_PLACE (MAX_PLACE)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .cfg        (cfg_ff),
      .win_clear  (win_clear),
      .queue_full (queue_full),
      .job_push   (job_push),
      .job        (job)
   );

   // job queue
   sfr_job_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (job),
      .pop      (job_pop),
      .full     (queue_full),
      .head     (head)
   );

   // emission and output limit
   sfr_back #(
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .out_limit (cfg_ff.out_limit),
      .pop       (job_pop),
      .rsp_ch    (rsp_ch)
   );

   // a bare end marker only ever closes a text
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.byte_valid |-> rsp_ch.out_last)
      else $error("bare marker without out_last");

   // length is only carried on the final word
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.out_last |-> rsp_ch.out_length == '0)
      else $error("out_length set on a non-final word");

   // a final byte counts itself, so the total cannot be zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.byte_valid && rsp_ch.out_last |-> rsp_ch.out_length != '0)
      else $error("final byte with zero length");

   // no job is written into a full queue
   assert property (@(posedge clock) disable iff (reset)
      job_push |-> !queue_full)
      else $error("job pushed into full queue");

endmodule

`default_nettype wire

// File: src/sfr_front.sv
// ----------------------------------------------------------------------------
// sfr_front
// takes text words, keeps the match window and turns each word into a job
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_front #(
   parameter int MAX_FIND  = sfr_pkg::MAX_FIND_DEF,
   parameter int MAX_PLACE = sfr_pkg::MAX_PLACE_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   sfr_req_if.sink               req_ch,
   input  wire sfr_pkg::cfg_type cfg,
   input  wire logic             win_clear,
   input  wire logic             queue_full,
   output logic                  job_push,
   output sfr_pkg::job_type      job
);

   localparam int LB = sfr_pkg::LEN_BITS;
   localparam int BB = sfr_pkg::BYTE_BITS;

   logic [BB-1:0] win_ff [MAX_FIND];
   logic [BB-1:0] win_in [MAX_FIND];
   logic [BB-1:0] cur    [MAX_FIND];
   logic [LB-1:0] fill_ff;
   logic [LB-1:0] fill_in;
   logic [LB-1:0] fill_eff;
   logic [LB-1:0] fill_next;
   logic [LB-1:0] flen;
   logic [LB-1:0] plen;
   logic          full;
   logic          match;
   logic          accept;

   assign req_ch.ready = !queue_full;
   assign accept       = req_ch.valid && req_ch.ready;

   // clamp the lengths to what the block supports
   always_comb begin
      if (cfg.find_len == '0) begin
         flen = LB'(1);
      end else if (cfg.find_len > LB'(MAX_FIND)) begin
         flen = LB'(MAX_FIND);
      end else begin
         flen = cfg.find_len;
      end
      if (cfg.place_len > LB'(MAX_PLACE)) begin
         plen = LB'(MAX_PLACE);
      end else begin
         plen = cfg.place_len;
      end
   end

   // window with the new word dropped in, and the pattern compare
   always_comb begin
      fill_eff  = (fill_ff >= flen) ? '0 : fill_ff;
      fill_next = fill_eff + LB'(1);
      full      = (fill_next == flen);
      match     = 1'b1;
      for (int i = 0; i < MAX_FIND; i++) begin
         cur[i] = (LB'(i) == fill_eff) ? req_ch.in_byte : win_ff[i];
         if (LB'(i) < flen && cur[i] != cfg.find_pattern[BB*i +: BB]) begin
            match = 1'b0;
         end
      end
   end

   // classify the word into a job and the next window
   always_comb begin
      job.last = req_ch.in_last;
      for (int i = 0; i < sfr_pkg::JOB_SLOTS; i++) begin
         job.bytes[i] = (full && match) ? cfg.place_pattern[BB*i +: BB] : '0;
      end
      for (int i = 0; i < MAX_FIND; i++) begin
         if (!(full && match)) begin
            job.bytes[i] = cur[i];
         end
      end
      for (int i = 0; i < MAX_FIND; i++) begin
         win_in[i] = cur[i];
      end
      if (full && match) begin
         job.count = plen;
         fill_in   = '0;
      end else if (full) begin
         // oldest byte out, window slides by one; a final word releases the whole window
         job.count = req_ch.in_last ? flen : LB'(1);
         fill_in   = req_ch.in_last ? '0 : flen - LB'(1);
         for (int i = 0; i < MAX_FIND - 1; i++) begin
            win_in[i] = cur[i + 1];
         end
      end else begin
         job.count = req_ch.in_last ? fill_next : '0;
         fill_in   = req_ch.in_last ? '0 : fill_next;
      end
      job_push = accept && (job.count != '0 || req_ch.in_last);
   end

   // fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (win_clear) begin
         fill_ff <= '0;
      end else if (accept) begin
         fill_ff <= fill_in;
      end
   end

   // window bytes
   always_ff @(posedge clock) begin
      if (accept) begin
         win_ff <= win_in;
      end
   end

endmodule

`default_nettype wire

// File: src/sfr_job_queue.sv
// ----------------------------------------------------------------------------
// sfr_job_queue
// short fifo of jobs between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_job_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire sfr_pkg::job_type push_job,
   input  wire logic             pop,
   output logic                  full,
   output sfr_pkg::queue_head_type head
);

   localparam int PB = sfr_pkg::QPTR_BITS;
   localparam int CB = sfr_pkg::QCNT_BITS;

   sfr_pkg::job_type slot_ff [sfr_pkg::QUEUE_DEPTH];
   logic [PB-1:0]    wr_ptr_ff;
   logic [PB-1:0]    rd_ptr_ff;
   logic [CB-1:0]    cnt_ff;
   logic             do_pop;

   assign full       = (cnt_ff == CB'(sfr_pkg::QUEUE_DEPTH));
   assign head.valid = (cnt_ff != '0);
   assign head.job   = slot_ff[rd_ptr_ff];
   assign do_pop     = pop && head.valid;

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PB'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + PB'(1);
         end
         if (push && !do_pop) begin
            cnt_ff <= cnt_ff + CB'(1);
         end else if (!push && do_pop) begin
            cnt_ff <= cnt_ff - CB'(1);
         end
      end
   end

   // job storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

// File: src/sfr_back.sv
// ----------------------------------------------------------------------------
// sfr_back
// walks the job bytes, applies the output limit and drives the result register
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_back #(
   parameter int COUNT_BITS = sfr_pkg::COUNT_BITS_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire sfr_pkg::queue_head_type head,
   input  wire logic [sfr_pkg::LIMIT_BITS-1:0] out_limit,
   output logic                         pop,
   sfr_rsp_if.source                    rsp_ch
);

   localparam int LB = sfr_pkg::LEN_BITS;
   localparam int BB = sfr_pkg::BYTE_BITS;
   localparam logic [32:0] COUNT_MAX = (33'd1 << COUNT_BITS) - 33'd1;

   logic [LB-1:0]         idx_ff;
   logic [LB-1:0]         idx_in;
   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;
   logic [COUNT_BITS-1:0] count_inc;
   logic [31:0]           count32;
   logic [31:0]           inc32;
   logic [31:0]           limit32;
   logic [31:0]           len32;
   logic                  advance;
   logic                  room_ok;
   logic                  one_left;
   logic                  more;
   logic                  final_byte;

   logic                            valid_ff,  valid_in;
   logic [BB-1:0]                   byte_ff,   byte_in;
   logic                            bvalid_ff, bvalid_in;
   logic                            last_ff,   last_in;
   logic [sfr_pkg::LIMIT_BITS-1:0]  length_ff, length_in;

   assign advance   = !valid_ff || rsp_ch.ready;
   assign count_inc = count_ff + COUNT_BITS'(1);
   assign count32   = 32'(count_ff);
   assign inc32     = count32 + 32'd1;
   assign limit32   = 32'(out_limit);

   // limit check: room for this byte, and whether it is the last that fits
   assign room_ok  = (count32 < limit32) && (count32 < COUNT_MAX[31:0]);
   assign one_left = (inc32 >= limit32) || (inc32 >= COUNT_MAX[31:0]);
   assign more     = (idx_ff < head.job.count);

   // step through the head job
   always_comb begin
      pop        = 1'b0;
      idx_in     = idx_ff;
      count_in   = count_ff;
      final_byte = 1'b0;
      valid_in   = valid_ff && !rsp_ch.ready;
      byte_in    = byte_ff;
      bvalid_in  = bvalid_ff;
      last_in    = last_ff;
      length_in  = length_ff;
      len32      = 32'(count_inc);
      if (head.valid && advance) begin
         if (more && room_ok) begin
            final_byte = (idx_ff + LB'(1) == head.job.count) || one_left;
            valid_in   = 1'b1;
            byte_in    = head.job.bytes[idx_ff[2:0]];
            bvalid_in  = 1'b1;
            last_in    = head.job.last && final_byte;
            length_in  = (head.job.last && final_byte) ? len32[15:0] : '0;
            count_in   = (head.job.last && final_byte) ? '0 : count_inc;
            pop        = final_byte;
            idx_in     = final_byte ? '0 : idx_ff + LB'(1);
         end else begin
            // nothing left to emit: bare end marker on the final word
            pop    = 1'b1;
            idx_in = '0;
            if (head.job.last) begin
               len32     = count32;
               valid_in  = 1'b1;
               byte_in   = '0;
               bvalid_in = 1'b0;
               last_in   = 1'b1;
               length_in = len32[15:0];
               count_in  = '0;
            end
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
         count_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
         count_ff <= count_in;
      end
   end

   // result word register
   always_ff @(posedge clock) begin
      byte_ff   <= byte_in;
      bvalid_ff <= bvalid_in;
      last_ff   <= last_in;
      length_ff <= length_in;
   end

   assign rsp_ch.valid      = valid_ff;
   assign rsp_ch.out_byte   = byte_ff;
   assign rsp_ch.byte_valid = bvalid_ff;
   assign rsp_ch.out_last   = last_ff;
   assign rsp_ch.out_length = length_ff;

endmodule

`default_nettype wire

// File: bench/sfr_edit_checker.sv
// ----------------------------------------------------------------------------
// sfr_edit_checker
// watches the text, edited and csr channels of the find-and-replace block,
// keeps its own copy of the window and settings, and checks every edited word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfr_edit_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   input  wire logic                            req_ready,
   input  wire logic [sfr_pkg::BYTE_BITS-1:0]   req_in_byte,
   input  wire logic                            req_in_last,
   input  wire logic                            rsp_valid,
   input  wire logic                            rsp_ready,
   input  wire logic [sfr_pkg::BYTE_BITS-1:0]   rsp_out_byte,
   input  wire logic                            rsp_byte_valid,
   input  wire logic                            rsp_out_last,
   input  wire logic [sfr_pkg::LIMIT_BITS-1:0]  rsp_out_length,
   input  wire logic                            csr_valid,
   input  wire logic                            csr_ready,
   input  wire logic [sfr_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  wire logic [sfr_pkg::PAT_BITS-1:0]    csr_data,
   output int                                   fail_count,
   output int                                   words_due,
   output int                                   words_checked
);

   localparam int BYB        = sfr_pkg::BYTE_BITS;
   localparam int LNB        = sfr_pkg::LEN_BITS;
   localparam int PTB        = sfr_pkg::PAT_BITS;
   localparam int LMB        = sfr_pkg::LIMIT_BITS;
   localparam int MAXF       = sfr_pkg::MAX_FIND_DEF;
   localparam int MAXP       = sfr_pkg::MAX_PLACE_DEF;
   localparam int COUNT_CEIL = (1 << sfr_pkg::COUNT_BITS_DEF) - 1;

   typedef struct packed {
      logic [BYB-1:0] out_byte;
      logic           byte_valid;
      logic           out_last;
      logic [LMB-1:0] out_length;
   } edit_word_type;

   // settings as last written
   logic [PTB-1:0] find_pat;
   logic [LNB-1:0] find_len_r;
   logic [PTB-1:0] place_pat;
   logic [LNB-1:0] place_len_r;
   logic [LMB-1:0] limit_r;

   // sliding window and running output count
   logic [BYB-1:0] window [0:MAXF-1];
   int             window_fill;
   int             emitted;
   int             fails;
   int             checked;

   edit_word_type edits_due[$];
   edit_word_type step_edits[$];

   task automatic clear_all();
      int i;
      find_pat    = '0;
      find_len_r  = 4'd1;
      place_pat   = '0;
      place_len_r = '0;
      limit_r     = '1;
      for (i = 0; i < MAXF; i++) window[i] = '0;
      window_fill = 0;
      emitted     = 0;
      edits_due.delete();
      step_edits.delete();
   endtask

   // a byte goes out only while below the limit and the counter ceiling
   task automatic emit_byte(input logic [BYB-1:0] value);
      if (emitted < int'(limit_r) && emitted < COUNT_CEIL) begin
         step_edits.push_back('{out_byte: value, byte_valid: 1'b1, out_last: 1'b0,
                                out_length: '0});
         emitted++;
      end
   endtask

   // edited words released by one text word
   task automatic replace_step(input logic [BYB-1:0] value, input logic final_word);
      int            flen;
      int            plen;
      int            i;
      bit            hit;
      edit_word_type tail;
      flen = int'(find_len_r);
      if (flen == 0) flen = 1;
      if (flen > MAXF) flen = MAXF;
      plen = int'(place_len_r);
      if (plen > MAXP) plen = MAXP;

      if (window_fill >= flen) window_fill = 0;
      window[window_fill] = value;
      window_fill++;

      // full window: replace on a hit, otherwise release the oldest byte
      if (window_fill == flen) begin
         hit = 1'b1;
         for (i = 0; i < flen; i++)
            if (window[i] != find_pat[8*i +: 8]) hit = 1'b0;
         if (hit) begin
            for (i = 0; i < plen; i++) emit_byte(place_pat[8*i +: 8]);
            window_fill = 0;
         end else begin
            emit_byte(window[0]);
            for (i = 0; i < window_fill - 1; i++) window[i] = window[i + 1];
            window_fill--;
         end
      end

      // end of text: flush, mark the last word with the total
      if (final_word) begin
         for (i = 0; i < window_fill; i++) emit_byte(window[i]);
         window_fill = 0;
         if (step_edits.size() == 0)
            step_edits.push_back('{out_byte: '0, byte_valid: 1'b0, out_last: 1'b0,
                                   out_length: '0});
         tail            = step_edits.pop_back();
         tail.out_last   = 1'b1;
         tail.out_length = emitted[LMB-1:0];
         step_edits.push_back(tail);
         emitted = 0;
      end

      while (step_edits.size() > 0) edits_due.push_back(step_edits.pop_front());
   endtask

   task automatic check_field(input string name, input logic [LMB-1:0] want,
                              input logic [LMB-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         fails++;
      end
   endtask

   // monitor: compare, then take settings, then predict
   always @(posedge clock) begin
      edit_word_type want;
      if (reset) begin
         clear_all();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (edits_due.size() == 0) begin
               $error("edited word with nothing outstanding: out_byte %0h out_last %0b",
                      rsp_out_byte, rsp_out_last);
               fails++;
            end else begin
               want = edits_due.pop_front();
               checked++;
               check_field("out_byte", LMB'(want.out_byte), LMB'(rsp_out_byte));
               check_field("byte_valid", LMB'(want.byte_valid), LMB'(rsp_byte_valid));
               check_field("out_last", LMB'(want.out_last), LMB'(rsp_out_last));
               check_field("out_length", want.out_length, rsp_out_length);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               sfr_pkg::REG_FIND_PATTERN:  find_pat = csr_data;
               sfr_pkg::REG_FIND_LEN: begin
                  find_len_r  = csr_data[LNB-1:0];
                  window_fill = 0;
               end
               sfr_pkg::REG_PLACE_PATTERN: place_pat = csr_data;
               sfr_pkg::REG_PLACE_LEN:     place_len_r = csr_data[LNB-1:0];
               sfr_pkg::REG_OUT_LIMIT:     limit_r = csr_data[LMB-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) replace_step(req_in_byte, req_in_last);
      end
      fail_count    <= fails;
      words_due     <= edits_due.size();
      words_checked <= checked;
   end

   initial begin
      fails   = 0;
      checked = 0;
   end

endmodule

// File: bench/tb_stream_find_and_replace.sv
// ----------------------------------------------------------------------------
// tb_stream_find_and_replace
// drives texts and register settings into the find-and-replace block under
// shifting back-pressure and sender gaps; the checker judges every edited word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_stream_find_and_replace;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int DRAIN_CYCLES  = 16;
   localparam int RANDOM_WORDS  = 300;
   localparam int SETTING_WORDS = 32;

   localparam int BYB = sfr_pkg::BYTE_BITS;
   localparam int LNB = sfr_pkg::LEN_BITS;
   localparam int PTB = sfr_pkg::PAT_BITS;
   localparam int LMB = sfr_pkg::LIMIT_BITS;

   logic clock;
   logic reset;

   sfr_req_if req_ch ();
   sfr_rsp_if rsp_ch ();
   sfr_csr_if csr_ch ();

   int fail_count;
   int words_due;
   int words_checked;
   int cycle_count;
   int send_idle;
   int recv_idle;
   int words_sent;
   int settings_used;

   // setting about to be written
   logic [PTB-1:0] set_find;
   logic [LNB-1:0] set_flen;
   logic [PTB-1:0] set_place;
   logic [LNB-1:0] set_plen;
   logic [LMB-1:0] set_limit;

   logic [BYB-1:0] text_bytes[$];

   stream_find_and_replace u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   sfr_edit_checker u_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_ch.valid),
      .req_ready      (req_ch.ready),
      .req_in_byte    (req_ch.in_byte),
      .req_in_last    (req_ch.in_last),
      .rsp_valid      (rsp_ch.valid),
      .rsp_ready      (rsp_ch.ready),
      .rsp_out_byte   (rsp_ch.out_byte),
      .rsp_byte_valid (rsp_ch.byte_valid),
      .rsp_out_last   (rsp_ch.out_last),
      .rsp_out_length (rsp_ch.out_length),
      .csr_valid      (csr_ch.valid),
      .csr_ready      (csr_ch.ready),
      .csr_index      (csr_ch.index),
      .csr_data       (csr_ch.data),
      .fail_count     (fail_count),
      .words_due      (words_due),
      .words_checked  (words_checked)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // cycle limit
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d edited words still due", cycle_count, words_due);
      $display("FAIL stream_find_and_replace");
      $finish;
   end

   // receiver back-pressure
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   // one text word; valid stays high for a following word
   task automatic send_word(input logic [BYB-1:0] value, input logic final_word);
      while ($urandom_range(99) < send_idle) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.in_byte <= value;
      req_ch.in_last <= final_word;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      words_sent++;
   endtask

   task automatic send_text();
      int i;
      for (i = 0; i < text_bytes.size(); i++)
         send_word(text_bytes[i], i == text_bytes.size() - 1);
   endtask

   task automatic park_req();
      req_ch.valid <= 1'b0;
   endtask

   // wait for every edited word, then let the back run dry
   task automatic settle();
      do @(posedge clock); while (words_due != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input sfr_pkg::csr_reg_type idx,
                            input logic [PTB-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
   endtask

   task automatic apply_setting();
      csr_write(sfr_pkg::REG_FIND_PATTERN, set_find);
      csr_write(sfr_pkg::REG_FIND_LEN, PTB'(set_flen));
      csr_write(sfr_pkg::REG_PLACE_PATTERN, set_place);
      csr_write(sfr_pkg::REG_PLACE_LEN, PTB'(set_plen));
      csr_write(sfr_pkg::REG_OUT_LIMIT, PTB'(set_limit));
      csr_ch.valid <= 1'b0;
      settings_used++;
   endtask

   // random setting, or an extreme one at the start of each phase
   task automatic pick_setting(input int phase, input bit extreme);
      int r;
      set_find  = {$urandom, $urandom};
      set_place = {$urandom, $urandom};
      r = $urandom_range(9);
      if (r == 0) set_flen = '0;
      else if (r == 1) set_flen = 4'($urandom_range(9, 15));
      else set_flen = 4'($urandom_range(1, 8));
      r = $urandom_range(9);
      if (r == 0) set_plen = 4'($urandom_range(9, 15));
      else if (r < 3) set_plen = '0;
      else set_plen = 4'($urandom_range(0, 8));
      r = $urandom_range(3);
      if (r == 0) set_limit = 16'($urandom_range(0, 24));
      else if (r == 1) set_limit = '1;
      else set_limit = 16'($urandom_range(25, 65535));
      if (extreme) begin
         case (phase)
            0: begin
               set_flen  = 4'd8;
               set_plen  = 4'd8;
               set_limit = '1;
            end
            1: begin
               set_flen  = 4'd1;
               set_plen  = '0;
               set_limit = '0;
            end
            default: begin
               set_find  = '0;
               set_place = '1;
               set_flen  = 4'd15;
               set_plen  = 4'd15;
               set_limit = 16'd1;
            end
         endcase
      end
   endtask

   // mostly whole patterns, some cut short or spoiled, some loose bytes
   task automatic build_text();
      int             flen;
      int             target;
      int             r;
      int             cut;
      int             i;
      int             pos;
      logic [BYB-1:0] spoil;
      flen = int'(set_flen);
      if (flen == 0) flen = 1;
      if (flen > 8) flen = 8;
      target = $urandom_range(1, 24);
      text_bytes.delete();
      while (text_bytes.size() < target) begin
         r = $urandom_range(99);
         if (r < 45) begin
            for (i = 0; i < flen; i++) text_bytes.push_back(set_find[8*i +: 8]);
         end else if (r < 60) begin
            cut = $urandom_range(1, flen);
            for (i = 0; i < cut - 1; i++) text_bytes.push_back(set_find[8*i +: 8]);
            spoil = 8'($urandom_range(1, 255));
            text_bytes.push_back(set_find[8*(cut-1) +: 8] ^ spoil);
         end else if (r < 80) begin
            pos = $urandom_range(0, flen - 1);
            text_bytes.push_back(set_find[8*pos +: 8]);
         end else begin
            text_bytes.push_back(8'($urandom));
         end
      end
   endtask

   // stimulus and verdict
   initial begin
      int phase;
      int phase_words;
      int setting_words;
      bit first_setting;

      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.in_byte <= '0;
      req_ch.in_last <= 1'b0;
      csr_ch.valid   <= 1'b0;
      csr_ch.index   <= sfr_pkg::REG_FIND_PATTERN;
      csr_ch.data    <= '0;
      send_idle     = 14;
      recv_idle     = 68;
      words_sent    = 0;
      settings_used = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset settings delete each zero byte; both texts end on a bare marker
      text_bytes = '{8'hFF, 8'h00};
      send_text();
      text_bytes = '{8'h00};
      send_text();

      // empty pattern length, oversized replacement
      set_find  = '1;
      set_flen  = '0;
      set_place = 64'h0123_4567_89AB_CDEF;
      set_plen  = 4'd12;
      set_limit = '1;
      park_req();
      settle();
      apply_setting();
      text_bytes = '{8'hFF, 8'h7E, 8'hFF};
      send_text();

      // longest pattern with a false start, deleted
      set_find  = 64'h4847_4645_4443_4241;
      set_flen  = 4'd8;
      set_place = '0;
      set_plen  = '0;
      park_req();
      settle();
      apply_setting();
      text_bytes = '{8'h41, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h00};
      send_text();

      // zero limit drops everything; oversized pattern length
      set_find  = '0;
      set_flen  = 4'd15;
      set_place = '1;
      set_plen  = 4'd8;
      set_limit = '0;
      park_req();
      settle();
      apply_setting();
      text_bytes = '{8'h12, 8'h34};
      send_text();

      // pattern length rewritten mid-text drops the held bytes; limit of three
      set_find  = 64'h63_6261;
      set_flen  = 4'd3;
      set_place = 64'h5958;
      set_plen  = 4'd2;
      set_limit = 16'd3;
      park_req();
      settle();
      apply_setting();
      send_word(8'h61, 1'b0);
      send_word(8'h62, 1'b0);
      park_req();
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_write(sfr_pkg::REG_FIND_LEN, PTB'(4'd3));
      csr_ch.valid <= 1'b0;
      text_bytes = '{8'h63, 8'h61, 8'h62, 8'h63, 8'h7A};
      send_text();

      // random texts in three idling phases
      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle = 14;
               recv_idle = 68;
            end
            1: begin
               send_idle = 68;
               recv_idle = 14;
            end
            default: begin
               send_idle = 0;
               recv_idle = 0;
            end
         endcase
         phase_words   = 0;
         first_setting = 1'b1;
         while (phase_words < RANDOM_WORDS / 3) begin
            pick_setting(phase, first_setting);
            first_setting = 1'b0;
            park_req();
            settle();
            apply_setting();
            setting_words = 0;
            while (setting_words < SETTING_WORDS) begin
               build_text();
               send_text();
               setting_words += text_bytes.size();
            end
            phase_words += setting_words;
         end
      end

      park_req();
      settle();
      $display("run covered %0d text words over %0d register settings, %0d edited words checked",
               words_sent, settings_used, words_checked);
      if (fail_count == 0 && words_due == 0) begin
         $display("PASS stream_find_and_replace");
      end else begin
         $display("FAIL stream_find_and_replace");
      end
      $finish;
   end

endmodule
